>>> sv/clt_pkg.sv
// types, constants and helper functions for the command line tokenizer
// used by clt_step and command_line_tokenizer_unit; no dependencies
package clt_pkg;

   localparam int unsigned MAX_SLOTS_LIMIT = 64;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_CR     = 8'h0d;

   localparam logic [1:0] CSR_ESCAPE_CHAR  = 2'd0;
   localparam logic [1:0] CSR_COMMENT_CHAR = 2'd1;
   localparam logic [1:0] CSR_MAX_SLOTS    = 2'd2;

   localparam logic [6:0] SLOT_CAP = (MAX_SLOTS_LIMIT < 64) ? 7'(MAX_SLOTS_LIMIT) : 7'd64;

   typedef enum logic [4:0] {
      MODE_BETWEEN = 5'b00001,
      MODE_PLAIN   = 5'b00010,
      MODE_QUOTED  = 5'b00100,
      MODE_SKIP    = 5'b01000,
      MODE_DONE    = 5'b10000
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       escape_pending;
      logic       quote_is_single;
      logic       token_nonempty;
      logic [5:0] tokens_found;
   } scan_state_type;

   typedef struct packed {
      logic [7:0] escape_char;
      logic [7:0] comment_char;
      logic [6:0] max_slots;
   } csr_type;

   typedef struct packed {
      logic       has_result;
      logic [7:0] out_char;
      logic       char_valid;
      logic       token_end;
      logic [5:0] token_index;
      logic       line_end;
      logic [5:0] token_count;
   } result_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic [7:0] translate(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == CHAR_N) r = CHAR_LF;
      else if (c == CHAR_T) r = CHAR_TAB;
      else if (c == CHAR_R) r = CHAR_CR;
      return r;
   endfunction

endpackage

>>> sv/clt_step.sv
// next-state and result logic for one line byte
// depends on clt_pkg
module clt_step (
   input  clt_pkg::scan_state_type state,
   input  clt_pkg::csr_type        csr,
   input  logic [7:0]              ch,
   input  logic                    line_last,
   output clt_pkg::scan_state_type state_next,
   output clt_pkg::result_type     result
);

   logic [6:0] slot_lim;
   logic       esc_hit;
   logic [7:0] qch;
   logic       cv;
   logic       tend;
   logic [7:0] oc;
   logic [5:0] idx;
   clt_pkg::scan_state_type s;

   always_comb begin
      slot_lim = csr.max_slots;
      if (slot_lim == 7'd0) slot_lim = 7'd1;
      if (slot_lim > clt_pkg::SLOT_CAP) slot_lim = clt_pkg::SLOT_CAP;
   end

   assign esc_hit = (csr.escape_char != 8'd0) && (ch == csr.escape_char);
   assign qch     = state.quote_is_single ? clt_pkg::CHAR_SQUOTE : clt_pkg::CHAR_DQUOTE;

   always_comb begin
      s    = state;
      cv   = 1'b0;
      tend = 1'b0;
      oc   = 8'd0;
      idx  = 6'd0;
      if (ch != 8'd0) begin
         case (state.mode)
            clt_pkg::MODE_BETWEEN: begin
               if ({1'b0, state.tokens_found} + 7'd1 >= slot_lim) begin
                  s.mode = clt_pkg::MODE_DONE;
               end else if (clt_pkg::is_sep(ch)) begin
                  s.mode = clt_pkg::MODE_BETWEEN;
               end else if (csr.comment_char != 8'd0 && ch == csr.comment_char) begin
                  s.mode = clt_pkg::MODE_DONE;
               end else if (ch == clt_pkg::CHAR_DQUOTE || ch == clt_pkg::CHAR_SQUOTE) begin
                  s.mode            = clt_pkg::MODE_QUOTED;
                  s.quote_is_single = (ch == clt_pkg::CHAR_SQUOTE);
                  s.token_nonempty  = 1'b0;
                  s.escape_pending  = 1'b0;
               end else if (esc_hit) begin
                  s.mode           = clt_pkg::MODE_PLAIN;
                  s.token_nonempty = 1'b0;
                  s.escape_pending = 1'b1;
               end else begin
                  s.mode           = clt_pkg::MODE_PLAIN;
                  s.token_nonempty = 1'b0;
                  s.escape_pending = 1'b0;
                  cv               = 1'b1;
                  oc               = ch;
               end
            end
            clt_pkg::MODE_PLAIN, clt_pkg::MODE_QUOTED: begin
               if (state.escape_pending) begin
                  s.escape_pending = 1'b0;
                  cv               = 1'b1;
                  oc               = clt_pkg::translate(ch);
               end else if (state.mode == clt_pkg::MODE_PLAIN && clt_pkg::is_sep(ch)) begin
                  tend   = 1'b1;
                  s.mode = clt_pkg::MODE_BETWEEN;
               end else if (state.mode == clt_pkg::MODE_QUOTED && ch == qch) begin
                  tend   = 1'b1;
                  s.mode = clt_pkg::MODE_SKIP;
               end else if (esc_hit) begin
                  s.escape_pending = 1'b1;
               end else begin
                  cv = 1'b1;
                  oc = ch;
               end
            end
            clt_pkg::MODE_SKIP: begin
               s.mode = clt_pkg::MODE_BETWEEN;
            end
            clt_pkg::MODE_DONE: begin
               s.mode = clt_pkg::MODE_DONE;
            end
            default: begin
               s.mode = clt_pkg::MODE_DONE;
            end
         endcase
      end

      if (line_last && (s.mode == clt_pkg::MODE_PLAIN || s.mode == clt_pkg::MODE_QUOTED)) begin
         if (s.escape_pending) begin
            cv               = 1'b1;
            oc               = csr.escape_char;
            s.escape_pending = 1'b0;
         end
         tend = 1'b1;
      end

      if (cv) begin
         s.token_nonempty = 1'b1;
         idx              = s.tokens_found;
      end
      if (tend) begin
         if (s.token_nonempty) begin
            idx            = s.tokens_found;
            s.tokens_found = s.tokens_found + 6'd1;
         end else begin
            tend = 1'b0;
         end
         s.token_nonempty = 1'b0;
      end

      result.out_char    = cv ? oc : 8'd0;
      result.char_valid  = cv;
      result.token_end   = tend;
      result.token_index = idx;
      result.line_end    = line_last;
      result.token_count = s.tokens_found;
      result.has_result  = cv || tend || line_last;

      if (line_last) begin
         s.mode            = clt_pkg::MODE_BETWEEN;
         s.escape_pending  = 1'b0;
         s.quote_is_single = 1'b0;
         s.token_nonempty  = 1'b0;
         s.tokens_found    = 6'd0;
      end
      state_next = s;
   end

endmodule

>>> sv/command_line_tokenizer_unit.sv
// top level of the command line tokenizer: csr registers, scan state and result register
// depends on clt_pkg and clt_step
//
// Takes one command line byte per cycle and returns token characters with token and line
// end marks. An item is accepted in every cycle while the result register is empty or being
// taken; its result appears on the rsp side in the next cycle. Each item gives at most one
// result; separators or quotes ending no token, escape openers, idle zero bytes give none.
// The csr port is always ready and takes effect from the next item.
module command_line_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,   // line_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_char, token_index, token_count, zero pad
   output logic [1:0]  rsp_tuser,   // char_valid, token_end
   output logic        rsp_tlast,   // line_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   clt_pkg::csr_type        csr_ff;
   clt_pkg::csr_type        csr_in;
   clt_pkg::scan_state_type state_ff;
   clt_pkg::scan_state_type state_in;
   clt_pkg::scan_state_type state_next;
   clt_pkg::result_type     result;
   clt_pkg::result_type     rsp_ff;
   clt_pkg::result_type     rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    req_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   clt_step u_step (
      .state      (state_ff),
      .csr        (csr_ff),
      .ch         (req_tdata),
      .line_last  (req_tlast),
      .state_next (state_next),
      .result     (result)
   );

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            clt_pkg::CSR_ESCAPE_CHAR:  csr_in.escape_char  = csr_data;
            clt_pkg::CSR_COMMENT_CHAR: csr_in.comment_char = csr_data;
            clt_pkg::CSR_MAX_SLOTS:    csr_in.max_slots    = csr_data[6:0];
            default:                   csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         state_in = state_next;
         if (result.has_result) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.escape_char  <= 8'd92;
         csr_ff.comment_char <= 8'd35;
         csr_ff.max_slots    <= 7'd16;
         state_ff.mode            <= clt_pkg::MODE_BETWEEN;
         state_ff.escape_pending  <= 1'b0;
         state_ff.quote_is_single <= 1'b0;
         state_ff.token_nonempty  <= 1'b0;
         state_ff.tokens_found    <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.token_count, rsp_ff.token_index, rsp_ff.out_char};
   assign rsp_tuser  = {rsp_ff.token_end, rsp_ff.char_valid};
   assign rsp_tlast  = rsp_ff.line_end;

   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=>
         state_ff.tokens_found == 6'd0 && state_ff.mode == clt_pkg::MODE_BETWEEN)
      else $error("line end did not clear scan state");

   a_token_end_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.token_end |-> rsp_ff.token_count != 6'd0)
      else $error("token end with zero token count");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.char_valid |-> rsp_ff.out_char == 8'd0)
      else $error("out_char set without char_valid");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule

>>> bench/tb_top.sv
// self-checking bench for command_line_tokenizer_unit: directed and random command lines,
// a byte-level tokenizer model in the bench and per-field checking of every rsp transaction
// depends on clt_pkg and command_line_tokenizer_unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } line_byte_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       token_end;
      logic [5:0] token_index;
      logic       line_end;
      logic [5:0] token_count;
   } token_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = clt_pkg::CSR_ESCAPE_CHAR;
   logic [7:0]  csr_data = 8'h00;

   line_byte_type  line_bytes_q[$];
   token_beat_type expected_beats[$];

   bit          req_fired = 1'b0;
   bit          csr_fired = 1'b0;
   int          stall_pct = 6;
   int          idle_cycles = 0;
   int          mismatches = 0;
   int          bytes_taken = 0;
   int          beats_checked = 0;
   int          lines_closed = 0;
   int          tokens_closed = 0;
   int          settings_run = 0;

   // tokenizer model state and register copies
   logic [7:0]        cfg_escape;
   logic [7:0]        cfg_comment;
   logic [6:0]        cfg_slots;
   clt_pkg::mode_type sc_mode;
   logic              sc_escape;
   logic              sc_single;
   logic              sc_nonempty;
   logic [5:0]        sc_found;

   command_line_tokenizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_scan();
      sc_mode = clt_pkg::MODE_BETWEEN;
      sc_escape = 1'b0;
      sc_single = 1'b0;
      sc_nonempty = 1'b0;
      sc_found = 6'd0;
   endfunction

   function automatic void tokenize_byte(input logic [7:0] c, input logic last);
      logic           cv, tend, lend, esc_hit, sep;
      logic [7:0]     oc, qch;
      logic [5:0]     idx;
      logic [6:0]     bound;
      token_beat_type beat;
      cv = 1'b0;
      tend = 1'b0;
      lend = 1'b0;
      oc = 8'h00;
      idx = 6'd0;
      qch = sc_single ? clt_pkg::CHAR_SQUOTE : clt_pkg::CHAR_DQUOTE;
      esc_hit = (cfg_escape != 8'h00) && (c == cfg_escape);
      sep = (c == clt_pkg::CHAR_SPACE) || (c == clt_pkg::CHAR_TAB);
      bound = (cfg_slots == 7'd0) ? 7'd1 : cfg_slots;
      if (bound > clt_pkg::SLOT_CAP) bound = clt_pkg::SLOT_CAP;
      if (c != 8'h00) begin
         case (sc_mode)
            clt_pkg::MODE_BETWEEN: begin
               if ({1'b0, sc_found} + 7'd1 >= bound) sc_mode = clt_pkg::MODE_DONE;
               else if (sep) sc_mode = clt_pkg::MODE_BETWEEN;
               else if (cfg_comment != 8'h00 && c == cfg_comment)
                  sc_mode = clt_pkg::MODE_DONE;
               else if (c == clt_pkg::CHAR_DQUOTE || c == clt_pkg::CHAR_SQUOTE) begin
                  sc_mode = clt_pkg::MODE_QUOTED;
                  sc_single = (c == clt_pkg::CHAR_SQUOTE);
                  sc_nonempty = 1'b0;
                  sc_escape = 1'b0;
               end else if (esc_hit) begin
                  sc_mode = clt_pkg::MODE_PLAIN;
                  sc_nonempty = 1'b0;
                  sc_escape = 1'b1;
               end else begin
                  sc_mode = clt_pkg::MODE_PLAIN;
                  sc_nonempty = 1'b0;
                  sc_escape = 1'b0;
                  cv = 1'b1;
                  oc = c;
               end
            end
            clt_pkg::MODE_PLAIN, clt_pkg::MODE_QUOTED: begin
               if (sc_escape) begin
                  sc_escape = 1'b0;
                  cv = 1'b1;
                  case (c)
                     clt_pkg::CHAR_N: oc = clt_pkg::CHAR_LF;
                     clt_pkg::CHAR_T: oc = clt_pkg::CHAR_TAB;
                     clt_pkg::CHAR_R: oc = clt_pkg::CHAR_CR;
                     default:         oc = c;
                  endcase
               end else if (sc_mode == clt_pkg::MODE_PLAIN && sep) begin
                  tend = 1'b1;
                  sc_mode = clt_pkg::MODE_BETWEEN;
               end else if (sc_mode == clt_pkg::MODE_QUOTED && c == qch) begin
                  tend = 1'b1;
                  sc_mode = clt_pkg::MODE_SKIP;
               end else if (esc_hit) begin
                  sc_escape = 1'b1;
               end else begin
                  cv = 1'b1;
                  oc = c;
               end
            end
            clt_pkg::MODE_SKIP: sc_mode = clt_pkg::MODE_BETWEEN;
            default: ;
         endcase
      end
      if (last && (sc_mode == clt_pkg::MODE_PLAIN || sc_mode == clt_pkg::MODE_QUOTED)) begin
         // escape still open at the line end comes out as itself
         if (sc_escape) begin
            cv = 1'b1;
            oc = cfg_escape;
            sc_escape = 1'b0;
         end
         tend = 1'b1;
      end
      if (cv) begin
         sc_nonempty = 1'b1;
         idx = sc_found;
      end
      if (tend) begin
         if (sc_nonempty) begin
            idx = sc_found;
            sc_found = sc_found + 6'd1;
         end else begin
            tend = 1'b0;
         end
         sc_nonempty = 1'b0;
      end
      beat.token_count = sc_found;
      if (last) begin
         lend = 1'b1;
         clear_scan();
      end
      if (cv || tend || lend) begin
         beat.out_char = cv ? oc : 8'h00;
         beat.char_valid = cv;
         beat.token_end = tend;
         beat.token_index = idx;
         beat.line_end = lend;
         expected_beats.push_back(beat);
      end
   endfunction

   // driver: req and rsp_tready change on the falling edge
   always @(negedge clock) begin
      line_byte_type item;
      if (!reset) begin
         if (!req_tvalid || req_fired) begin
            if (line_bytes_q.size() != 0 && $urandom_range(99) >= stall_pct) begin
               item = line_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= item.ch;
               req_tlast <= item.last;
            end else begin
               req_tvalid <= 1'b0;
               req_tdata <= 8'($urandom);
               req_tlast <= 1'($urandom);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: transactions sampled on the rising edge
   always @(posedge clock) begin
      token_beat_type got, want;
      bit             rsp_fired;
      if (reset) begin
         cfg_escape = 8'd92;
         cfg_comment = 8'd35;
         cfg_slots = 7'd16;
         clear_scan();
         req_fired = 1'b0;
         csr_fired = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired = req_tvalid && req_tready;
         csr_fired = csr_valid && csr_ready;
         rsp_fired = rsp_tvalid && rsp_tready;
         if (rsp_fired) begin
            got.out_char = rsp_tdata[7:0];
            got.token_index = rsp_tdata[13:8];
            got.token_count = rsp_tdata[19:14];
            got.char_valid = rsp_tuser[0];
            got.token_end = rsp_tuser[1];
            got.line_end = rsp_tlast;
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected rsp: char %h cv %b te %b idx %0d le %b cnt %0d",
                           $realtime, got.out_char, got.char_valid, got.token_end,
                           got.token_index, got.line_end, got.token_count);
            end else begin
               want = expected_beats.pop_front();
               beats_checked++;
               if (want.line_end) lines_closed++;
               if (want.token_end) tokens_closed++;
               if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                   got.token_end !== want.token_end || got.token_index !== want.token_index ||
                   got.line_end !== want.line_end || got.token_count !== want.token_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] rsp mismatch: char %h/%h cv %b/%b te %b/%b ",
                               "idx %0d/%0d le %b/%b cnt %0d/%0d (expected/actual)"},
                              $realtime, want.out_char, got.out_char,
                              want.char_valid, got.char_valid, want.token_end, got.token_end,
                              want.token_index, got.token_index, want.line_end, got.line_end,
                              want.token_count, got.token_count);
               end
            end
         end
         // a byte taken at the same edge as a register write still sees the old value
         if (req_fired) begin
            bytes_taken++;
            tokenize_byte(req_tdata, req_tlast);
         end
         if (csr_fired) begin
            case (csr_index)
               clt_pkg::CSR_ESCAPE_CHAR:  cfg_escape = csr_data;
               clt_pkg::CSR_COMMENT_CHAR: cfg_comment = csr_data;
               clt_pkg::CSR_MAX_SLOTS:    cfg_slots = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_fired || rsp_fired || csr_fired) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] c, input logic last);
      line_byte_type item;
      item.ch = c;
      item.last = last;
      line_bytes_q.push_back(item);
   endtask

   function automatic logic [7:0] word_byte(input logic [7:0] esc, input logic [7:0] cmt);
      case ($urandom_range(15))
         0:       return clt_pkg::CHAR_SPACE;
         1:       return clt_pkg::CHAR_TAB;
         2:       return clt_pkg::CHAR_DQUOTE;
         3:       return clt_pkg::CHAR_SQUOTE;
         4:       return esc;
         5:       return cmt;
         6:       return clt_pkg::CHAR_N;
         7:       return clt_pkg::CHAR_T;
         8:       return clt_pkg::CHAR_R;
         default: return 8'($urandom_range(33, 126));
      endcase
   endfunction

   // well-formed line with random content, some quotes left open
   task automatic push_line(input logic [7:0] esc, input logic [7:0] cmt);
      int         ntok;
      logic [7:0] q;
      ntok = $urandom_range(0, 7);
      for (int k = 0; k < ntok; k++) begin
         repeat ($urandom_range(1, 2))
            push_byte($urandom_range(1) ? clt_pkg::CHAR_SPACE : clt_pkg::CHAR_TAB, 1'b0);
         if ($urandom_range(9) == 0) push_byte(8'h00, 1'b0);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: repeat ($urandom_range(1, 6)) push_byte(word_byte(esc, cmt), 1'b0);
            5, 6: begin
               q = $urandom_range(1) ? clt_pkg::CHAR_SQUOTE : clt_pkg::CHAR_DQUOTE;
               push_byte(q, 1'b0);
               repeat ($urandom_range(0, 5)) push_byte(word_byte(esc, cmt), 1'b0);
               if ($urandom_range(7) != 0) begin
                  push_byte(q, 1'b0);
                  push_byte(word_byte(esc, cmt), 1'b0);
               end
            end
            7: begin
               push_byte(esc, 1'b0);
               push_byte(word_byte(esc, cmt), 1'b0);
            end
            8: begin
               push_byte(cmt, 1'b0);
               repeat ($urandom_range(0, 3)) push_byte(word_byte(esc, cmt), 1'b0);
            end
            default: push_byte(esc, 1'b0);
         endcase
      end
      if ($urandom_range(2) == 0) push_byte(8'h00, 1'b1);
      else push_byte(word_byte(esc, cmt), 1'b1);
   endtask

   // raw bytes over the whole range, closed by a line end
   task automatic push_noise();
      repeat ($urandom_range(3, 12)) push_byte(8'($urandom), ($urandom_range(9) == 0));
      push_byte(8'($urandom), 1'b1);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (line_bytes_q.size() != 0 || req_tvalid || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_setting(input logic [7:0] esc, input logic [7:0] cmt,
                              input logic [7:0] slots, input int budget, input bit long_line);
      write_csr(clt_pkg::CSR_ESCAPE_CHAR, esc);
      write_csr(clt_pkg::CSR_COMMENT_CHAR, cmt);
      write_csr(clt_pkg::CSR_MAX_SLOTS, slots);
      settings_run++;
      // more one-letter tokens than any slot count allows
      if (long_line) begin
         repeat (70) begin
            push_byte(8'($urandom_range(97, 122)), 1'b0);
            push_byte(clt_pkg::CHAR_SPACE, 1'b0);
         end
         push_byte(8'h00, 1'b1);
      end
      while (line_bytes_q.size() < budget) begin
         if ($urandom_range(4) == 0) push_noise();
         else push_line(esc, cmt);
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed line set under the reset register values
      push_byte(8'h00, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(clt_pkg::CHAR_SPACE, 1'b0);
      push_byte(clt_pkg::CHAR_TAB, 1'b0);
      push_byte(clt_pkg::CHAR_DQUOTE, 1'b0);
      push_byte(8'h78, 1'b0);
      push_byte(8'd92, 1'b0);
      push_byte(clt_pkg::CHAR_DQUOTE, 1'b0);
      push_byte(clt_pkg::CHAR_DQUOTE, 1'b0);
      push_byte(8'h7a, 1'b0);
      push_byte(clt_pkg::CHAR_SQUOTE, 1'b0);
      push_byte(clt_pkg::CHAR_DQUOTE, 1'b0);
      push_byte(clt_pkg::CHAR_SQUOTE, 1'b0);
      push_byte(clt_pkg::CHAR_SPACE, 1'b0);
      push_byte(8'd92, 1'b0);
      push_byte(clt_pkg::CHAR_N, 1'b0);
      push_byte(8'd92, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'd35, 1'b0);
      push_byte(8'h71, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(clt_pkg::CHAR_DQUOTE, 1'b0);
      push_byte(8'h6b, 1'b1);
      push_byte(clt_pkg::CHAR_SPACE, 1'b1);
      settle();

      run_setting(8'd92, 8'd35, 8'd16, 40, 1'b0);
      run_setting(8'd1, 8'd255, 8'd64, 150, 1'b1);
      run_setting(8'd255, 8'd1, 8'd1, 30, 1'b0);
      run_setting(clt_pkg::CHAR_SQUOTE, clt_pkg::CHAR_DQUOTE, 8'd2, 30, 1'b0);
      run_setting(clt_pkg::CHAR_SPACE, clt_pkg::CHAR_TAB, 8'd3, 30, 1'b0);
      run_setting(8'd0, 8'd0, 8'd127, 30, 1'b0);
      run_setting(clt_pkg::CHAR_T, clt_pkg::CHAR_SQUOTE, 8'd200, 50, 1'b1);
      run_setting(8'd92, 8'd35, 8'h80, 15, 1'b0);
      stall_pct = 0;
      run_setting(8'd92, 8'd35, 8'd16, 60, 1'b0);

      if (expected_beats.size() != 0) begin
         mismatches += expected_beats.size();
         $display("%0d expected rsp transactions never arrived", expected_beats.size());
      end
      $display("covered %0d command bytes under %0d register settings", bytes_taken,
               settings_run + 1);
      $display("checked %0d rsp transactions: %0d lines, %0d tokens", beats_checked,
               lines_closed, tokens_closed);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
sv/clt_pkg.sv
sv/clt_step.sv
sv/command_line_tokenizer_unit.sv
bench/tb_top.sv
